@@ hw/rtl/msvb_pkg.sv @@
// Shared types, constants and lookup tables of the sine voice bank.
`default_nettype none

package msvb_pkg;

  localparam int TRACKS       = 8;
  localparam int TRK_W        = 3;
  localparam int EMIT_COUNT   = 8;
  localparam int MASK_W       = 8;
  localparam int OP_W         = 2;
  localparam int PITCH_W      = 7;
  localparam int LEVEL_W      = 7;
  localparam int PHASE_BITS   = 32;
  localparam int SAMPLE_RATE  = 48000;
  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
  localparam int QUARTER      = SINE_ENTRIES / 4;
  localparam int QTR_W        = SINE_BITS - 1;
  localparam int MAG_W        = 15;
  localparam int PROD_W       = MAG_W + LEVEL_W;
  localparam int LEVEL_BIAS   = 317;
  localparam int RECIP_W      = 23;
  localparam int RECIP        = 6763729;
  localparam int RECIP_SHIFT  = 32;
  localparam int QUO_W        = 13;
  localparam int SAMPLE_W     = 14;

  localparam logic [63:0] POLY_C1 = 64'd1686629713;
  localparam logic [63:0] POLY_C3 = 64'd693598668;
  localparam logic [63:0] POLY_C5 = 64'd85569306;
  localparam logic [63:0] POLY_C7 = 64'd5026995;
  localparam logic [63:0] POLY_C9 = 64'd172272;

  localparam logic [16:0] SEMITONE_Q16 [12] = '{
    17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
    17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_TICK     = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NOTE,
    ST_TICK_RD,
    ST_TICK_EVAL,
    ST_TICK_CALC,
    ST_TICK_OUT
  } state_t;

  typedef struct packed {
    logic                  active;
    logic [PITCH_W-1:0]    pitch;
    logic [LEVEL_W-1:0]    level;
    logic [PHASE_BITS-1:0] phase;
  } voice_t;

  typedef struct packed {
    logic                  start;
    logic [PHASE_BITS-1:0] phase;
    logic [LEVEL_W-1:0]    level;
  } calc_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] sample;
  } calc_rsp_t;

  typedef logic [MAG_W-1:0]      sine_tab_t [0:QUARTER];
  typedef logic [PHASE_BITS-1:0] incr_tab_t [0:(1 << PITCH_W) - 1];

  function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] y;
    x2 = (x * x) >> 30;
    t  = POLY_C7 - ((x2 * POLY_C9) >> 30);
    t  = POLY_C5 - ((x2 * t) >> 30);
    t  = POLY_C3 - ((x2 * t) >> 30);
    t  = POLY_C1 - ((x2 * t) >> 30);
    y  = (x * t) >> 30;
    y  = (y + 64'd16384) >> 15;
    if (y > 64'd32767) begin
      y = 64'd32767;
    end
    return y[MAG_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int k = 0; k <= QUARTER; k++) begin
      tab[k] = quarter_sine(64'(k) << (32 - SINE_BITS));
    end
    return tab;
  endfunction

  function automatic logic [PHASE_BITS-1:0] phase_step(input int p);
    int          d;
    int          oct;
    int          s;
    int          e;
    logic [63:0] a;
    logic [63:0] q;
    logic [63:0] r;
    d   = p + 51;
    oct = d / 12;
    s   = d % 12;
    a   = 64'd440 * 64'(SEMITONE_Q16[s]);
    e   = oct + PHASE_BITS - 26;
    if (e < 0) begin
      q = (a >> (-e)) / 64'(SAMPLE_RATE);
    end else begin
      q = a / 64'(SAMPLE_RATE);
      r = a % 64'(SAMPLE_RATE);
      for (int i = 0; i < e; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= 64'(SAMPLE_RATE)) begin
          r    = r - 64'(SAMPLE_RATE);
          q[0] = 1'b1;
        end
      end
    end
    return q[PHASE_BITS-1:0];
  endfunction

  function automatic incr_tab_t build_incr_tab();
    incr_tab_t tab;
    for (int p = 0; p < (1 << PITCH_W); p++) begin
      tab[p] = phase_step(p);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();
  localparam incr_tab_t INCR_TAB = build_incr_tab();

endpackage

`default_nettype wire

@@ hw/rtl/msvb_if.sv @@
// Handshake channel interfaces: note/tick input, sample output, mask write.
`default_nettype none

interface msvb_in_if;
  logic                         valid;
  logic                         ready;
  logic [msvb_pkg::OP_W-1:0]    opcode;
  logic [msvb_pkg::TRK_W-1:0]   track;
  logic [msvb_pkg::PITCH_W-1:0] pitch;
  logic [msvb_pkg::LEVEL_W-1:0] velocity;
  modport source (output valid, opcode, track, pitch, velocity, input ready);
  modport sink (input valid, opcode, track, pitch, velocity, output ready);
endinterface

interface msvb_out_if;
  logic                                valid;
  logic                                ready;
  logic [msvb_pkg::TRK_W-1:0]          out_track;
  logic signed [msvb_pkg::SAMPLE_W-1:0] sample_value;
  logic                                last;
  modport source (output valid, out_track, sample_value, last, input ready);
  modport sink (input valid, out_track, sample_value, last, output ready);
endinterface

interface msvb_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [msvb_pkg::MASK_W-1:0] instrument_mask;
  modport source (output valid, instrument_mask, input ready);
  modport sink (input valid, instrument_mask, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/msvb_sine_scale.sv @@
// Four-stage sine lookup and level scaling pipeline for one voice sample.
`default_nettype none

module msvb_sine_scale (
  input  logic                clk,
  input  logic                rst_n,
  input  msvb_pkg::calc_req_t req,
  output msvb_pkg::calc_rsp_t rsp
);

  logic [msvb_pkg::SINE_BITS-1:0] idx;
  logic [1:0]                     quad;
  logic [msvb_pkg::QTR_W-1:0]     k_ext;
  logic [msvb_pkg::QTR_W-1:0]     fold;

  logic                           v1_r, v2_r, v3_r, v4_r;
  logic                           neg1_r, neg2_r, neg3_r;
  logic [msvb_pkg::MAG_W-1:0]     mag1_r;
  logic [msvb_pkg::LEVEL_W-1:0]   lvl1_r;
  logic [msvb_pkg::PROD_W-1:0]    prod2_r;
  logic [msvb_pkg::PROD_W+msvb_pkg::RECIP_W-1:0] full;
  logic [msvb_pkg::QUO_W-1:0]     quo3_r;
  logic signed [msvb_pkg::SAMPLE_W-1:0] smp4_r;
  logic [msvb_pkg::SAMPLE_W-1:0]  quo_ext;

  assign idx   = req.phase[msvb_pkg::PHASE_BITS-1 -: msvb_pkg::SINE_BITS];
  assign quad  = idx[msvb_pkg::SINE_BITS-1 -: 2];
  assign k_ext = {1'b0, idx[msvb_pkg::SINE_BITS-3:0]};
  assign fold  = quad[0] ? (msvb_pkg::QTR_W'(msvb_pkg::QUARTER) - k_ext) : k_ext;

  assign full = (msvb_pkg::PROD_W + msvb_pkg::RECIP_W)'(prod2_r)
              * (msvb_pkg::PROD_W + msvb_pkg::RECIP_W)'(msvb_pkg::RECIP);
  assign quo_ext = msvb_pkg::SAMPLE_W'(quo3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= req.start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    mag1_r  <= msvb_pkg::SINE_TAB[fold];
    neg1_r  <= quad[1];
    lvl1_r  <= req.level;
    prod2_r <= msvb_pkg::PROD_W'(mag1_r) * msvb_pkg::PROD_W'(lvl1_r)
             + msvb_pkg::PROD_W'(msvb_pkg::LEVEL_BIAS);
    neg2_r  <= neg1_r;
    quo3_r  <= full[msvb_pkg::RECIP_SHIFT +: msvb_pkg::QUO_W];
    neg3_r  <= neg2_r;
    smp4_r  <= neg3_r ? $signed(msvb_pkg::SAMPLE_W'(0) - quo_ext) : $signed(quo_ext);
  end

  assign rsp.done   = v4_r;
  assign rsp.sample = smp4_r;

endmodule

`default_nettype wire

@@ hw/rtl/midi_sine_voice_bank_unit.sv @@
// Sine voice bank top level: voice memory, event sequencer and output register.
// One sine voice per track; the voice state (active, pitch, level, phase) sits in
// an eight-entry memory with a registered read and is updated read-modify-write.
// A note event is taken in idle and written back in the note state. A tick walks
// the tracks in order: each track is read and evaluated, a sounding voice then
// passes through the sine/scale pipeline, and the output register is loaded; a
// stalled output holds the sequencer at that track. The memory's single
// read-modify-write path and the scale pipeline set this per-track sequence.
// After the last beat of a tick is loaded the block takes the next item while
// that beat waits. The mask port is always ready.
`default_nettype none

module midi_sine_voice_bank_unit (
  input  logic        clk,
  input  logic        rst_n,
  msvb_in_if.sink     in_bus,
  msvb_out_if.source  out_bus,
  msvb_cfg_if.sink    cfg_bus
);

  msvb_pkg::state_t              state_r, state_nxt;
  logic [msvb_pkg::MASK_W-1:0]   mask_r;
  logic [msvb_pkg::TRK_W-1:0]    trk_r;
  logic [msvb_pkg::PITCH_W-1:0]  pitch_r;
  logic [msvb_pkg::LEVEL_W-1:0]  vel_r;
  logic                          note_on_r;

  msvb_pkg::voice_t              voice_mem [msvb_pkg::TRACKS];
  logic [msvb_pkg::TRACKS-1:0]   vld_r;
  msvb_pkg::voice_t              rd_ent_r;
  logic                          rd_vld_r;
  logic [msvb_pkg::TRK_W-1:0]    rd_addr;
  msvb_pkg::voice_t              entry;
  msvb_pkg::voice_t              wr_ent;
  logic                          wr_en;

  msvb_pkg::calc_req_t           calc_req;
  msvb_pkg::calc_rsp_t           calc_rsp;

  logic                          in_rdy;
  logic                          in_take;
  logic                          out_load;
  logic                          smp_clr;
  logic                          is_last;
  logic signed [msvb_pkg::SAMPLE_W-1:0] smp_r;

  logic                          out_valid_r;
  logic [msvb_pkg::TRK_W-1:0]    out_track_r;
  logic signed [msvb_pkg::SAMPLE_W-1:0] out_sample_r;
  logic                          out_last_r;

  assign in_take = in_bus.valid && in_rdy;
  assign is_last = (trk_r == msvb_pkg::TRK_W'(msvb_pkg::EMIT_COUNT - 1));
  assign rd_addr = (state_r == msvb_pkg::ST_IDLE) ? in_bus.track : trk_r;
  assign entry   = rd_vld_r ? rd_ent_r : '0;

  always_comb begin
    state_nxt      = state_r;
    in_rdy         = 1'b0;
    wr_en          = 1'b0;
    wr_ent         = entry;
    calc_req.start = 1'b0;
    calc_req.phase = entry.phase;
    calc_req.level = entry.level;
    out_load       = 1'b0;
    smp_clr        = 1'b0;
    case (state_r)
      msvb_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_bus.valid) begin
          if (in_bus.opcode inside {msvb_pkg::OP_NOTE_ON, msvb_pkg::OP_NOTE_OFF}) begin
            state_nxt = msvb_pkg::ST_NOTE;
          end else if (in_bus.opcode == msvb_pkg::OP_TICK) begin
            state_nxt = msvb_pkg::ST_TICK_RD;
          end
        end
      end
      msvb_pkg::ST_NOTE: begin
        wr_en = 1'b1;
        if (note_on_r) begin
          wr_ent.active = 1'b1;
          wr_ent.pitch  = pitch_r;
          wr_ent.level  = vel_r;
        end else if (entry.pitch == pitch_r) begin
          wr_ent.active = 1'b0;
        end
        state_nxt = msvb_pkg::ST_IDLE;
      end
      msvb_pkg::ST_TICK_RD: begin
        state_nxt = msvb_pkg::ST_TICK_EVAL;
      end
      msvb_pkg::ST_TICK_EVAL: begin
        if (mask_r[trk_r] && entry.active) begin
          wr_en          = 1'b1;
          wr_ent.phase   = entry.phase + msvb_pkg::INCR_TAB[entry.pitch];
          calc_req.start = 1'b1;
          state_nxt      = msvb_pkg::ST_TICK_CALC;
        end else begin
          smp_clr   = 1'b1;
          state_nxt = msvb_pkg::ST_TICK_OUT;
        end
      end
      msvb_pkg::ST_TICK_CALC: begin
        if (calc_rsp.done) begin
          state_nxt = msvb_pkg::ST_TICK_OUT;
        end
      end
      msvb_pkg::ST_TICK_OUT: begin
        if (!out_valid_r || out_bus.ready) begin
          out_load  = 1'b1;
          state_nxt = is_last ? msvb_pkg::ST_IDLE : msvb_pkg::ST_TICK_RD;
        end
      end
      default: begin
        state_nxt = msvb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msvb_pkg::ST_IDLE;
      mask_r      <= '0;
      vld_r       <= '0;
      trk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_bus.valid) begin
        mask_r <= cfg_bus.instrument_mask;
      end
      if (wr_en) begin
        vld_r[trk_r] <= 1'b1;
      end
      if (in_take) begin
        trk_r <= (in_bus.opcode == msvb_pkg::OP_TICK) ? '0 : in_bus.track;
      end else if (out_load) begin
        trk_r <= trk_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      voice_mem[trk_r] <= wr_ent;
    end
    rd_ent_r <= voice_mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pitch_r   <= in_bus.pitch;
      vel_r     <= in_bus.velocity;
      note_on_r <= (in_bus.opcode == msvb_pkg::OP_NOTE_ON);
    end
    if (smp_clr) begin
      smp_r <= '0;
    end else if (calc_rsp.done) begin
      smp_r <= calc_rsp.sample;
    end
    if (out_load) begin
      out_track_r  <= trk_r;
      out_sample_r <= smp_r;
      out_last_r   <= is_last;
    end
  end

  msvb_sine_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (calc_req),
    .rsp   (calc_rsp)
  );

  assign in_bus.ready         = in_rdy;
  assign cfg_bus.ready        = 1'b1;
  assign out_bus.valid        = out_valid_r;
  assign out_bus.out_track    = out_track_r;
  assign out_bus.sample_value = out_sample_r;
  assign out_bus.last         = out_last_r;

endmodule

`default_nettype wire
